FILE: hdl/ttlc_pkg.sv
// Package for the TTL service cache table.
// Holds request codes, the stored entry layout and the control and status bundles.
// No dependencies.
package ttlc_pkg;

  typedef enum logic [2:0] {
    REQ_LOOKUP  = 3'd0,
    REQ_ADD     = 3'd1,
    REQ_REFRESH = 3'd2,
    REQ_DELETE  = 3'd3,
    REQ_PURGE   = 3'd4,
    REQ_OLDEST  = 3'd5
  } req_t;

  localparam logic [31:0] EXPIRY_MARK  = 32'hFFFF_FFFF;
  localparam logic [31:0] OLDEST_LIMIT = 32'hFFFF_FFFE;
  localparam int unsigned COUNT_OUT_W  = 5;
  localparam logic [COUNT_OUT_W-1:0] COUNT_OUT_MAX = 5'd31;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] tag;
    logic [31:0] expiry;
  } entry_t;

  typedef struct packed {
    logic start;
    logic issue;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic issue_done;
    logic pipe_busy;
    logic out_free;
  } sts_t;

endpackage

FILE: hdl/ttl_service_cache_table.sv
// TTL service cache table: an ordered table of service entries walked once per
// request. The single read port of the entry memory reads one entry per cycle
// during the walk. Lookup, add, refresh, delete, purge and find-oldest all walk
// every used entry. A new request is accepted in the cycle after the previous
// result has been loaded into the output register, so requests do not overlap.
// A result waits while the output register still holds an unaccepted
// transaction. Configuration writes to the own address are always accepted and
// must only occur while the block is idle.
// Depends on ttlc_pkg, ttlc_ctrl and ttlc_datapath.
module ttl_service_cache_table
  import ttlc_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [31:0] entry_address,
  input  logic [31:0] url_tag,
  input  logic [31:0] max_age,
  input  logic [31:0] now_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        success,
  output logic        table_full,
  output logic [4:0]  removed_count,
  output logic        oldest_found,
  output logic [31:0] oldest_address,
  output logic [31:0] oldest_url_tag
);

  logic [31:0] own_address;
  cmd_t        cmd;
  sts_t        sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= '0;
    end else if (cfg_valid) begin
      own_address <= cfg_data;
    end
  end

  ttlc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ttlc_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .own_address    (own_address),
    .req_type       (req_type),
    .entry_address  (entry_address),
    .url_tag        (url_tag),
    .max_age        (max_age),
    .now_seconds    (now_seconds),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .success        (success),
    .table_full     (table_full),
    .removed_count  (removed_count),
    .oldest_found   (oldest_found),
    .oldest_address (oldest_address),
    .oldest_url_tag (oldest_url_tag)
  );

endmodule

FILE: hdl/ttlc_ctrl.sv
// Controller state machine of the TTL service cache table.
// Sequences the table walk and hands commands to ttlc_datapath; depends on ttlc_pkg.
module ttlc_ctrl
  import ttlc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = !sts.issue_done;
        if (sts.issue_done && !sts.pipe_busy) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_finish_needs_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> sts.out_free)
    else $error("Result was loaded while the output register was occupied.");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("A second transaction was accepted during a walk.");

  a_no_issue_past_end: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> !sts.issue_done)
    else $error("A read was issued beyond the used entries.");

endmodule

FILE: hdl/ttlc_datapath.sv
// Datapath of the TTL service cache table: entry memory, walk counters,
// request registers, accumulators and the output register. Depends on ttlc_pkg.
module ttlc_datapath
  import ttlc_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [31:0] own_address,
  input  logic [2:0]  req_type,
  input  logic [31:0] entry_address,
  input  logic [31:0] url_tag,
  input  logic [31:0] max_age,
  input  logic [31:0] now_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        success,
  output logic        table_full,
  output logic [4:0]  removed_count,
  output logic        oldest_found,
  output logic [31:0] oldest_address,
  output logic [31:0] oldest_url_tag
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int RW    = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_q;

  logic [2:0]       r_op;
  logic [31:0]      r_addr;
  logic [31:0]      r_tag;
  logic [31:0]      r_now;
  logic [31:0]      r_exp;
  logic [CNT_W-1:0] used_cnt;
  logic [CNT_W-1:0] rd_idx;
  logic [IDX_W-1:0] proc_idx;
  logic             proc_v;
  logic [CNT_W-1:0] wptr;
  logic [CNT_W-1:0] removed_cnt;
  logic             found;
  logic             best_found;
  logic [31:0]      best_exp;
  logic [31:0]      best_addr;
  logic [31:0]      best_tag;

  logic             match;
  logic             expired;
  logic             drop;
  logic             compact;
  logic             older;
  logic             own_hit;
  logic             full;
  logic             add_ok;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  entry_t           wr_data;
  logic [RW-1:0]    removed_ext;
  logic [4:0]       removed_sat;

  assign match   = proc_v && (rd_q.addr == r_addr) && (rd_q.tag == r_tag);
  assign expired = (rd_q.expiry == EXPIRY_MARK) || (r_now > rd_q.expiry);
  assign drop    = ((r_op == REQ_DELETE) && match) || ((r_op == REQ_PURGE) && expired);
  assign compact = proc_v && ((r_op == REQ_DELETE) || (r_op == REQ_PURGE));
  assign older   = proc_v && (r_op == REQ_OLDEST) && (rd_q.expiry < best_exp);
  assign own_hit = (r_addr == own_address);
  assign full    = (used_cnt == CNT_W'(TABLE_DEPTH));
  assign add_ok  = (r_op == REQ_ADD) && !own_hit && !found && !full;

  assign removed_ext = RW'(removed_cnt);
  assign removed_sat = (removed_ext > RW'(COUNT_OUT_MAX)) ? COUNT_OUT_MAX
                                                          : removed_ext[4:0];

  assign sts.issue_done = (rd_idx == used_cnt);
  assign sts.pipe_busy  = proc_v;
  assign sts.out_free   = !out_valid || out_ready;

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = used_cnt[IDX_W-1:0];
    wr_data = '{addr: r_addr, tag: r_tag, expiry: r_exp};
    priority if (cmd.finish && add_ok) begin
      wr_en = 1'b1;
    end else if (compact && !drop) begin
      wr_en   = 1'b1;
      wr_idx  = wptr[IDX_W-1:0];
      wr_data = rd_q;
    end else if ((r_op == REQ_REFRESH) && match) begin
      wr_en  = 1'b1;
      wr_idx = proc_idx;
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (cmd.issue) begin
      rd_q <= mem[rd_idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      r_op   <= req_type;
      r_addr <= entry_address;
      r_tag  <= url_tag;
      r_now  <= now_seconds;
      r_exp  <= now_seconds + max_age;
    end
    if (cmd.issue) begin
      proc_idx <= rd_idx[IDX_W-1:0];
    end
    if (cmd.start) begin
      best_exp  <= OLDEST_LIMIT;
      best_addr <= '0;
      best_tag  <= '0;
    end else if (older) begin
      best_exp  <= rd_q.expiry;
      best_addr <= rd_q.addr;
      best_tag  <= rd_q.tag;
    end
    if (cmd.finish) begin
      success        <= ((r_op == REQ_LOOKUP) && (own_hit || found)) || add_ok ||
                        (((r_op == REQ_REFRESH) || (r_op == REQ_DELETE)) && found);
      table_full     <= (r_op == REQ_ADD) && !own_hit && !found && full;
      removed_count  <= (r_op == REQ_PURGE) ? removed_sat : '0;
      oldest_found   <= best_found;
      oldest_address <= best_addr;
      oldest_url_tag <= best_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_cnt    <= '0;
      rd_idx      <= '0;
      proc_v      <= 1'b0;
      wptr        <= '0;
      removed_cnt <= '0;
      found       <= 1'b0;
      best_found  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      proc_v <= cmd.issue;
      if (cmd.start) begin
        rd_idx      <= '0;
        wptr        <= '0;
        removed_cnt <= '0;
        found       <= 1'b0;
        best_found  <= 1'b0;
      end else begin
        if (cmd.issue) begin
          rd_idx <= rd_idx + CNT_W'(1);
        end
        if (match) begin
          found <= 1'b1;
        end
        if (older) begin
          best_found <= 1'b1;
        end
        if (compact) begin
          if (drop) begin
            removed_cnt <= removed_cnt + CNT_W'(1);
          end else begin
            wptr <= wptr + CNT_W'(1);
          end
        end
      end
      if (cmd.finish) begin
        if (add_ok) begin
          used_cnt <= used_cnt + CNT_W'(1);
        end else if ((r_op == REQ_DELETE) || (r_op == REQ_PURGE)) begin
          used_cnt <= wptr;
        end
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_used_in_range: assert property (@(posedge clk) disable iff (rst)
    used_cnt <= CNT_W'(TABLE_DEPTH))
    else $error("Entry count exceeds the table depth.");

  a_finish_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("A finished request did not present a result.");

  a_compact_behind_read: assert property (@(posedge clk) disable iff (rst)
    compact |-> (wptr <= CNT_W'(proc_idx)))
    else $error("Compaction write pointer passed the entry being processed.");

endmodule

FILE: test/ttl_service_cache_table_checker.sv
`timescale 1ns / 1ps
// Checker for the TTL service cache table: watches the configuration, request and
// reply channels, keeps its own copy of the entry table and compares every reply.
// Depends on ttlc_pkg.
module ttl_service_cache_table_checker
  import ttlc_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [31:0] entry_address,
  input  logic [31:0] url_tag,
  input  logic [31:0] max_age,
  input  logic [31:0] now_seconds,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        success,
  input  logic        table_full,
  input  logic [4:0]  removed_count,
  input  logic        oldest_found,
  input  logic [31:0] oldest_address,
  input  logic [31:0] oldest_url_tag,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic                   success;
    logic                   table_full;
    logic [COUNT_OUT_W-1:0] removed_count;
    logic                   oldest_found;
    logic [31:0]            oldest_address;
    logic [31:0]            oldest_url_tag;
  } cache_reply_t;

  logic [31:0]  own_addr;
  logic [31:0]  held_addr   [TABLE_DEPTH];
  logic [31:0]  held_tag    [TABLE_DEPTH];
  logic [31:0]  held_expiry [TABLE_DEPTH];
  int           held_count;
  cache_reply_t due_replies [$];

  function automatic int find_entry(input logic [31:0] a, input logic [31:0] t);
    for (int i = 0; i < held_count; i++) begin
      if (held_addr[i] == a && held_tag[i] == t) return i;
    end
    return -1;
  endfunction

  task automatic serve_request(input logic [2:0] req, input logic [31:0] a,
                               input logic [31:0] t, input logic [31:0] age,
                               input logic [31:0] now, output cache_reply_t r);
    int          k;
    int          keep;
    int          dropped;
    logic [31:0] best;
    r = '0;
    k = find_entry(a, t);
    case (req)
      REQ_LOOKUP: begin
        r.success = (a == own_addr) || (k >= 0);
      end
      REQ_ADD: begin
        if (a != own_addr && k < 0) begin
          if (held_count >= TABLE_DEPTH) begin
            r.table_full = 1'b1;
          end else begin
            held_addr[held_count]   = a;
            held_tag[held_count]    = t;
            held_expiry[held_count] = now + age;
            held_count++;
            r.success = 1'b1;
          end
        end
      end
      REQ_REFRESH: begin
        if (k >= 0) begin
          held_expiry[k] = now + age;
          r.success = 1'b1;
        end
      end
      REQ_DELETE: begin
        if (k >= 0) begin
          for (int i = k; i < held_count - 1; i++) begin
            held_addr[i]   = held_addr[i + 1];
            held_tag[i]    = held_tag[i + 1];
            held_expiry[i] = held_expiry[i + 1];
          end
          held_count--;
          r.success = 1'b1;
        end
      end
      REQ_PURGE: begin
        keep = 0;
        dropped = 0;
        for (int i = 0; i < held_count; i++) begin
          if (held_expiry[i] == EXPIRY_MARK || now > held_expiry[i]) begin
            dropped++;
          end else begin
            held_addr[keep]   = held_addr[i];
            held_tag[keep]    = held_tag[i];
            held_expiry[keep] = held_expiry[i];
            keep++;
          end
        end
        held_count = keep;
        r.removed_count = (dropped > COUNT_OUT_MAX) ? COUNT_OUT_MAX : COUNT_OUT_W'(dropped);
      end
      REQ_OLDEST: begin
        best = OLDEST_LIMIT;
        for (int i = 0; i < held_count; i++) begin
          if (held_expiry[i] < best) begin
            best = held_expiry[i];
            r.oldest_found = 1'b1;
            r.oldest_address = held_addr[i];
            r.oldest_url_tag = held_tag[i];
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : monitor
    cache_reply_t want;
    if (rst) begin
      errors = 0;
      own_addr = '0;
      held_count = 0;
      due_replies.delete();
    end else begin
      if (cfg_valid && cfg_ready) own_addr = cfg_data;
      if (in_valid && in_ready) begin
        serve_request(req_type, entry_address, url_tag, max_age, now_seconds, want);
        due_replies = {due_replies, want};
      end
      if (out_valid && out_ready) begin
        if (due_replies.size() == 0) begin
          $display("%0t: reply with no request outstanding, expected none, actual %h",
                   $time, {success, table_full, removed_count, oldest_found,
                           oldest_address, oldest_url_tag});
          errors++;
        end else begin
          want = due_replies.pop_front();
          check_field("success", 32'(want.success), 32'(success));
          check_field("table_full", 32'(want.table_full), 32'(table_full));
          check_field("removed_count", 32'(want.removed_count), 32'(removed_count));
          check_field("oldest_found", 32'(want.oldest_found), 32'(oldest_found));
          check_field("oldest_address", want.oldest_address, oldest_address);
          check_field("oldest_url_tag", want.oldest_url_tag, oldest_url_tag);
        end
      end
    end
    pending <= due_replies.size();
  end

endmodule

FILE: test/ttl_service_cache_table_tb.sv
`timescale 1ns / 1ps
// Testbench top for the TTL service cache table: drives requests and own-address
// writes with random idling on both sides and gives the verdict.
// Depends on ttlc_pkg, ttl_service_cache_table and ttl_service_cache_table_checker.
module ttl_service_cache_table_tb;
  import ttlc_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int STALL_LIMIT = 4000;
  localparam int SEGMENT_ITEMS = 275;
  localparam logic [2:0] REQ_SPARE_LO = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  req_type = '0;
  logic [31:0] entry_address = '0;
  logic [31:0] url_tag = '0;
  logic [31:0] max_age = '0;
  logic [31:0] now_seconds = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        success;
  logic        table_full;
  logic [4:0]  removed_count;
  logic        oldest_found;
  logic [31:0] oldest_address;
  logic [31:0] oldest_url_tag;
  int          errors;
  int          pending;

  int          send_idle_pct = 35;
  int          recv_idle_pct = 65;
  int          quiet_cycles = 0;
  logic [31:0] own_setting = '0;
  logic [31:0] clock_now = '0;
  logic [31:0] addr_pool [8];
  logic [31:0] tag_pool  [4];

  ttl_service_cache_table #(.TABLE_DEPTH(TABLE_DEPTH)) DUT (.*);

  ttl_service_cache_table_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input logic [2:0] req, input logic [31:0] a,
                              input logic [31:0] t, input logic [31:0] age,
                              input logic [31:0] now);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid      <= 1'b1;
    req_type      <= req;
    entry_address <= a;
    url_tag       <= t;
    max_age       <= age;
    now_seconds   <= now;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_for_replies();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_own_address(input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_addr();
    int r;
    r = $urandom_range(99);
    if (r < 6) return own_setting;
    if (r < 11) return $urandom;
    return addr_pool[$urandom_range(7)];
  endfunction

  function automatic logic [31:0] pick_tag();
    if ($urandom_range(99) < 6) return $urandom;
    return tag_pool[$urandom_range(3)];
  endfunction

  function automatic logic [31:0] pick_age(input logic [31:0] now);
    int r;
    r = $urandom_range(99);
    if (r < 55) return $urandom_range(40);
    if (r < 70) return $urandom_range(2000);
    if (r < 82) return $urandom;
    if (r < 88) return EXPIRY_MARK - now;
    if (r < 94) return OLDEST_LIMIT - now;
    return 32'd0;
  endfunction

  function automatic logic [31:0] pick_now();
    int r;
    r = $urandom_range(99);
    if (r < 6) return $urandom;
    if (r < 8) return 32'd0;
    if (r < 10) return 32'hFFFF_FFFF;
    clock_now = clock_now + $urandom_range(4);
    return clock_now;
  endfunction

  task automatic send_mixed();
    int          r;
    logic [2:0]  code;
    logic [31:0] now;
    r = $urandom_range(99);
    if (r < 30) code = REQ_ADD;
    else if (r < 46) code = REQ_LOOKUP;
    else if (r < 60) code = REQ_REFRESH;
    else if (r < 73) code = REQ_DELETE;
    else if (r < 85) code = REQ_PURGE;
    else if (r < 97) code = REQ_OLDEST;
    else code = r[0] ? REQ_SPARE_HI : REQ_SPARE_LO;
    now = pick_now();
    send_request(code, pick_addr(), pick_tag(), pick_age(now), now);
  endtask

  initial begin : stimulus
    int          r;
    int          sent;
    bit          paused;
    logic [31:0] now;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    own_setting = 32'hC0A8_0001;
    write_own_address(own_setting);
    send_request(REQ_LOOKUP, own_setting, 32'd0, 32'd0, 32'd0);
    send_request(REQ_ADD, own_setting, 32'd5, 32'd10, 32'd0);
    send_request(REQ_LOOKUP, 32'h0A00_0001, 32'h1234, 32'd0, 32'd0);
    send_request(REQ_OLDEST, 32'd0, 32'd0, 32'd0, 32'd0);
    send_request(REQ_PURGE, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
    send_request(REQ_ADD, 32'h0A00_0001, 32'h1234, 32'd100, 32'd1000);
    send_request(REQ_ADD, 32'h0A00_0001, 32'h1234, 32'd7, 32'd7);
    send_request(REQ_LOOKUP, 32'h0A00_0001, 32'h1234, 32'd0, 32'd0);
    send_request(REQ_LOOKUP, 32'h0A00_0001, 32'hFFFF_EDCB, 32'd0, 32'd0);
    send_request(REQ_REFRESH, 32'h0A00_0001, 32'h1234, 32'hFFFF_FFFF, 32'd0);
    send_request(REQ_REFRESH, own_setting, 32'h1234, 32'd1, 32'd1);
    send_request(REQ_DELETE, own_setting, 32'h1234, 32'd0, 32'd0);
    send_request(REQ_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_ADD, 32'd0, 32'd0, 32'd0, 32'd5);
    send_request(REQ_ADD, 32'd0, 32'd1, 32'd0, 32'd5);
    send_request(REQ_OLDEST, 32'd0, 32'd0, 32'd0, 32'd0);
    send_request(REQ_PURGE, 32'd0, 32'd0, 32'd0, 32'd5);
    send_request(REQ_REFRESH, 32'd0, 32'd0, 32'hFFFF_FFFE, 32'd0);
    send_request(REQ_OLDEST, 32'd0, 32'd0, 32'd0, 32'd0);
    send_request(REQ_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0);
    send_request(REQ_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0);
    send_request(REQ_SPARE_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_PURGE, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);

    for (int seg = 0; seg < 6; seg++) begin
      wait_for_replies();
      addr_pool[0] = 32'd0;
      addr_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 8; i++) addr_pool[i] = $urandom;
      tag_pool[0] = 32'd0;
      tag_pool[1] = 32'hFFFF_FFFF;
      tag_pool[2] = $urandom;
      tag_pool[3] = $urandom;
      case (seg)
        0: own_setting = 32'hFFFF_FFFF;
        1: own_setting = addr_pool[2];
        2: own_setting = 32'd0;
        3: own_setting = $urandom;
        4: own_setting = addr_pool[4];
        default: own_setting = addr_pool[0];
      endcase
      write_own_address(own_setting);
      case (seg / 2)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct = 65;
        end
        1: begin
          send_idle_pct = 65;
          recv_idle_pct = 35;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      clock_now = (seg == 3) ? 32'hFFFF_FF00 : $urandom_range(5000);
      sent = 0;
      paused = 1'b0;
      while (sent < SEGMENT_ITEMS) begin
        r = $urandom_range(99);
        if (r < 25) begin
          repeat (18) begin
            now = pick_now();
            send_request(REQ_ADD, pick_addr(), pick_tag(), pick_age(now), now);
          end
          sent += 18;
        end else if (r < 85) begin
          repeat (20) send_mixed();
          sent += 20;
        end else begin
          clock_now = clock_now + $urandom_range(10, 300);
          send_request(REQ_PURGE, $urandom, $urandom, $urandom, clock_now);
          repeat (3) send_mixed();
          send_request(REQ_OLDEST, $urandom, $urandom, $urandom, clock_now);
          sent += 5;
        end
        if (!paused && sent >= SEGMENT_ITEMS / 2) begin
          wait_for_replies();
          paused = 1'b1;
        end
      end
    end

    wait_for_replies();
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
